// ===== rtl/rpwfd_pkg.sv =====
`default_nettype none
package rpwfd_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PILOT_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PILOT_MAX = 1'b1;

    localparam int CFG_DATA_W = 16;
    localparam logic [15:0] PILOT_MIN_RESET = 16'd5366;
    localparam logic [15:0] PILOT_MAX_RESET = 16'd9966;

    // width / 23 as multiply by ceil(2^21 / 23), exact for all 16-bit widths
    localparam logic [16:0] RECIP_23    = 17'd91181;
    localparam int          RECIP_SHIFT = 21;
    localparam logic [8:0]  UNIT_MAX    = 9'd511;

    // frame layout
    localparam logic [4:0] FIRST_PART_BITS = 5'd15;
    localparam logic [4:0] FRAME_BITS      = 5'd28;
    localparam logic [3:0] END_CODE        = 4'b0101;

    // input request
    typedef struct packed {
        logic        pulse_level;
        logic [15:0] pulse_width;
    } t_in_req;

    // result
    typedef struct packed {
        logic        frame_ok;
        logic [14:0] first_part;
        logic [12:0] second_part;
    } t_out_res;

    // classified pulse passed from front to back
    typedef struct packed {
        logic        is_high;
        logic        pilot_ok;
        logic [8:0]  unit;
        logic [16:0] width2;
    } t_pulse_cls;

endpackage
`default_nettype wire

// ===== rtl/rpwfd_front.sv =====
`default_nettype none
module rpwfd_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [rpwfd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [rpwfd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire rpwfd_pkg::t_in_req                  i_req,
    output rpwfd_pkg::t_pulse_cls                    o_cls
);

    logic [15:0] r_pilot_min;
    logic [15:0] r_pilot_max;
    logic [32:0] w_prod;
    logic [11:0] w_quot;

    // pilot bound registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pilot_min <= rpwfd_pkg::PILOT_MIN_RESET;
            r_pilot_max <= rpwfd_pkg::PILOT_MAX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rpwfd_pkg::CFG_PILOT_MIN: r_pilot_min <= i_cfg_data;
                rpwfd_pkg::CFG_PILOT_MAX: r_pilot_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // unit time candidate: width / 23 by reciprocal multiply
    assign w_prod = {17'd0, i_req.pulse_width} * {16'd0, rpwfd_pkg::RECIP_23};
    assign w_quot = w_prod[32:rpwfd_pkg::RECIP_SHIFT];

    // classify the request independent of decoder state
    always_comb begin
        o_cls.is_high  = i_req.pulse_level;
        o_cls.pilot_ok = (i_req.pulse_width > r_pilot_min) &&
                         (i_req.pulse_width < r_pilot_max);
        o_cls.unit     = (w_quot > {3'd0, rpwfd_pkg::UNIT_MAX}) ?
                         rpwfd_pkg::UNIT_MAX : w_quot[8:0];
        o_cls.width2   = {i_req.pulse_width, 1'b0};
    end

endmodule
`default_nettype wire

// ===== rtl/rpwfd_queue.sv =====
`default_nettype none
module rpwfd_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire rpwfd_pkg::t_pulse_cls i_data,
    output logic                       o_full,
    input  wire logic                  i_pop,
    output logic                       o_empty,
    output rpwfd_pkg::t_pulse_cls      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rpwfd_pkg::t_pulse_cls r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rpwfd_back.sv =====
`default_nettype none
module rpwfd_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cls_valid,
    input  wire rpwfd_pkg::t_pulse_cls i_cls,
    output logic                       o_cls_pop,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output rpwfd_pkg::t_out_res        o_out
);

    logic        r_receiving;
    logic [8:0]  r_unit;
    logic [4:0]  r_count;
    logic [14:0] r_first;
    logic [12:0] r_second;
    logic        r_out_valid;
    rpwfd_pkg::t_out_res r_out;

    logic        n_receiving;
    logic [8:0]  n_unit;
    logic [4:0]  n_count;
    logic [14:0] n_first;
    logic [12:0] n_second;
    logic        n_emit;
    rpwfd_pkg::t_out_res n_out;

    logic [16:0] w_u1;
    logic [16:0] w_u3;
    logic [16:0] w_u5;
    logic        w_bit0;
    logic        w_bit1;
    logic [4:0]  w_cnt_inc;
    logic        w_ok;

    // take a request when the result slot is free or draining
    assign o_cls_pop   = i_cls_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // unit multiples for the doubled-width compare
    assign w_u1 = {8'd0, r_unit};
    assign w_u3 = {8'd0, r_unit} + {7'd0, r_unit, 1'b0};
    assign w_u5 = {8'd0, r_unit} + {6'd0, r_unit, 2'b0};
    assign w_bit0 = (i_cls.width2 > w_u3) && (i_cls.width2 < w_u5);
    assign w_bit1 = (i_cls.width2 > w_u1) && (i_cls.width2 < w_u3);
    assign w_cnt_inc = r_count + 5'd1;

    // decoder state update
    always_comb begin
        n_receiving = r_receiving;
        n_unit      = r_unit;
        n_count     = r_count;
        n_first     = r_first;
        n_second    = r_second;
        n_emit      = 1'b0;
        n_out       = r_out;
        w_ok        = 1'b0;
        if (!r_receiving) begin
            if (!i_cls.is_high && i_cls.pilot_ok) begin
                n_receiving = 1'b1;
                n_unit      = i_cls.unit;
                n_count     = '0;
                n_first     = '0;
                n_second    = '0;
            end
        end else if (i_cls.is_high) begin
            if (w_bit0 || w_bit1) begin
                n_count = w_cnt_inc;
                if (w_cnt_inc <= rpwfd_pkg::FIRST_PART_BITS) begin
                    n_first = {r_first[13:0], w_bit1};
                end else begin
                    n_second = {r_second[11:0], w_bit1};
                end
                if (w_cnt_inc == rpwfd_pkg::FRAME_BITS) begin
                    n_receiving = 1'b0;
                    n_count     = '0;
                    n_emit      = 1'b1;
                    w_ok        = (n_second[3:0] == rpwfd_pkg::END_CODE);
                    if (!w_ok) begin
                        n_first  = '0;
                        n_second = '0;
                    end
                    n_out.frame_ok    = w_ok;
                    n_out.first_part  = n_first;
                    n_out.second_part = n_second;
                end
            end else begin
                // unclassifiable pulse drops the frame
                n_receiving = 1'b0;
                n_count     = '0;
            end
        end
    end

    // decoder registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving <= 1'b0;
            r_unit      <= '0;
            r_count     <= '0;
            r_first     <= '0;
            r_second    <= '0;
        end else if (o_cls_pop) begin
            r_receiving <= n_receiving;
            r_unit      <= n_unit;
            r_count     <= n_count;
            r_first     <= n_first;
            r_second    <= n_second;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cls_pop && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cls_pop && n_emit) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/remote_pulse_width_frame_decoder.sv =====
`default_nettype none
// channel   direction  handshake                     payload
// in        input      i_in_valid / o_in_ready       i_in  (pulse_level, pulse_width)
// out       output     o_out_valid / i_out_ready     o_out (frame_ok, first_part, second_part)
// cfg       input      i_cfg_we                      i_cfg_idx, i_cfg_data
//
// one pulse per cycle sustained while results are taken; an accepted pulse is written into
// the queue and, once popped, into the decoder state, and its result is visible then.
// while a result waits the decoder takes no pulses; the queue absorbs up to QUEUE_DEPTH
// more, then o_in_ready drops until the result is taken.
// synchronous active-low reset clears decoder state, the queue and the result slot,
// and loads the pilot bounds with their defaults; no clearing pass is needed.
module remote_pulse_width_frame_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire rpwfd_pkg::t_in_req               i_in,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output rpwfd_pkg::t_out_res                   o_out,
    input  wire logic                             i_cfg_we,
    input  wire logic [rpwfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rpwfd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    rpwfd_pkg::t_pulse_cls w_cls_in;
    rpwfd_pkg::t_pulse_cls w_cls_out;
    logic w_full;
    logic w_empty;
    logic w_pop;

    assign o_in_ready = !w_full;

    // classify incoming pulses
    rpwfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_in),
        .o_cls      (w_cls_in)
    );

    // queue between classifier and decoder
    rpwfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (w_cls_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_cls_out)
    );

    // frame decoder and result slot
    rpwfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_valid (!w_empty),
        .i_cls       (w_cls_out),
        .o_cls_pop   (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

// ===== tb/sv/remote_pulse_width_frame_decoder_test.sv =====
`timescale 1ns / 100ps
module remote_pulse_width_frame_decoder_test;
    import rpwfd_pkg::*;

    localparam int unsigned PILOT_UNITS  = 23;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          NO_ABORT     = -1;

    // dut connections
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_req               in_req   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_res              out_res;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // decoder mirror: pilot window and frame assembly state
    logic [15:0] pilot_lo;
    logic [15:0] pilot_hi;
    logic        rx_busy;
    logic [8:0]  unit_us;
    logic [4:0]  bits_seen;
    logic [14:0] head_bits;
    logic [12:0] tail_bits;
    t_out_res    expected_frames[$];

    // run bookkeeping
    logic        no_stall     = 1'b0;
    int unsigned pulses_sent  = 0;
    int unsigned frames_seen  = 0;
    int unsigned good_frames  = 0;
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;

    remote_pulse_width_frame_decoder u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // 100 MHz clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // mirror reset state
    task automatic reset_decoder_state();
        pilot_lo  = PILOT_MIN_RESET;
        pilot_hi  = PILOT_MAX_RESET;
        rx_busy   = 1'b0;
        unit_us   = '0;
        bits_seen = '0;
        head_bits = '0;
        tail_bits = '0;
    endtask

    // advance the mirror by one accepted pulse, queue any finished frame
    task automatic decode_pulse(input t_in_req p);
        int unsigned quot;
        int unsigned w2;
        int unsigned u;
        logic        bit_val;
        t_out_res    frame;
        if (!rx_busy) begin
            if (!p.pulse_level && p.pulse_width > pilot_lo && p.pulse_width < pilot_hi) begin
                quot      = p.pulse_width / PILOT_UNITS;
                unit_us   = (quot > UNIT_MAX) ? UNIT_MAX : quot[8:0];
                bits_seen = '0;
                head_bits = '0;
                tail_bits = '0;
                rx_busy   = 1'b1;
            end
            return;
        end
        if (!p.pulse_level)
            return;

        // classify with doubled width against 1, 3 and 5 units
        w2 = 2 * p.pulse_width;
        u  = unit_us;
        if (w2 > 3 * u && w2 < 5 * u) begin
            bit_val = 1'b0;
        end else if (w2 > u && w2 < 3 * u) begin
            bit_val = 1'b1;
        end else begin
            rx_busy   = 1'b0;
            bits_seen = '0;
            return;
        end

        bits_seen = bits_seen + 5'd1;
        if (bits_seen <= FIRST_PART_BITS)
            head_bits = {head_bits[13:0], bit_val};
        else
            tail_bits = {tail_bits[11:0], bit_val};
        if (bits_seen < FRAME_BITS)
            return;

        rx_busy   = 1'b0;
        bits_seen = '0;
        if (tail_bits[3:0] == END_CODE) begin
            frame.frame_ok    = 1'b1;
            frame.first_part  = head_bits;
            frame.second_part = tail_bits;
        end else begin
            head_bits = '0;
            tail_bits = '0;
            frame     = '0;
        end
        expected_frames.push_back(frame);
    endtask

    // send one pulse request and wait for it to be taken
    task automatic send_pulse(input logic level, input logic [15:0] width);
        int unsigned gap;
        t_in_req     req;
        gap             = no_stall ? 0 : $urandom_range(0, 3);
        req.pulse_level = level;
        req.pulse_width = width;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge clk); while (!in_ready);
        decode_pulse(req);
        pulses_sent++;
    endtask

    // let outstanding results drain, then give the pipeline time to settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        if (idx == CFG_PILOT_MIN)
            pilot_lo = data;
        else
            pilot_hi = data;
    endtask

    // reprogram the pilot window while the decoder is quiet
    task automatic set_bounds(input logic [15:0] lo, input logic [15:0] hi);
        wait_idle();
        write_reg(CFG_PILOT_MIN, lo);
        write_reg(CFG_PILOT_MAX, hi);
        cfg_we <= 1'b0;
    endtask

    // high pulse width that classifies as b under unit u; mode 0 low edge, 1 high edge, else random
    function automatic logic [15:0] bit_width(input int unsigned u, input logic b,
                                              input int unsigned mode);
        int unsigned lo;
        int unsigned hi;
        if (u == 0)
            return 16'($urandom_range(0, 3));
        if (b) begin
            lo = u / 2 + 1;
            hi = (3 * u - 1) / 2;
        end else begin
            lo = (3 * u) / 2 + 1;
            hi = (5 * u - 1) / 2;
        end
        case (mode)
            0:       return 16'(lo);
            1:       return 16'(hi);
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    // high pulse width that fits neither bit class
    function automatic logic [15:0] bad_width(input int unsigned u);
        case ($urandom_range(0, 3))
            0:       return 16'(u / 2);
            1:       return 16'((5 * u + 1) / 2);
            2:       return 16'hFFFF;
            default: return 16'($urandom_range((5 * u + 1) / 2, 65535));
        endcase
    endfunction

    // pilot width inside the current window, edges favored
    function automatic logic [15:0] pick_pilot();
        int lo;
        int hi;
        lo = int'(pilot_lo) + 1;
        hi = int'(pilot_hi) - 1;
        if (lo > hi)
            return 16'($urandom);
        case ($urandom_range(0, 4))
            0:       return 16'(lo);
            1:       return 16'(hi);
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    // pilot plus 28 data pulses, optional leading high pulse, low chatter and early abort
    task automatic send_frame(input logic [15:0] pilot_w, input logic [27:0] code,
                              input int abort_at, input int unsigned chatter_pct);
        int unsigned u;
        u = pilot_w / PILOT_UNITS;
        if (u > UNIT_MAX)
            u = UNIT_MAX;
        if ($urandom_range(0, 3) == 0)
            send_pulse(1'b1, 16'($urandom));
        send_pulse(1'b0, pilot_w);
        for (int i = 27; i >= 0; i--) begin
            if ($urandom_range(0, 99) < chatter_pct)
                send_pulse(1'b0, 16'($urandom));
            if (i == abort_at) begin
                send_pulse(1'b1, bad_width(u));
                return;
            end
            send_pulse(1'b1, bit_width(u, code[i], $urandom_range(0, 2)));
        end
    endtask

    // unstructured pulses, some hugging the pilot window edges
    task automatic send_noise(input int unsigned count);
        logic [15:0] width;
        repeat (count) begin
            case ($urandom_range(0, 3))
                0:       width = 16'($urandom);
                1:       width = 16'($urandom_range(0, 2000));
                2:       width = pilot_lo + 16'($urandom_range(0, 2)) - 16'd1;
                default: width = pilot_hi + 16'($urandom_range(0, 2)) - 16'd1;
            endcase
            send_pulse(1'($urandom), width);
        end
    endtask

    // pilot window edges, idle high pulses and the width extremes
    task automatic test_pilot_bounds();
        send_pulse(1'b0, 16'd0);
        send_pulse(1'b0, 16'hFFFF);
        send_pulse(1'b1, 16'd7000);
        send_pulse(1'b0, PILOT_MIN_RESET);
        send_pulse(1'b0, PILOT_MAX_RESET);
        send_pulse(1'b0, PILOT_MAX_RESET - 16'd1);
        send_pulse(1'b1, 16'hFFFF);
        send_pulse(1'b0, PILOT_MIN_RESET + 16'd1);
        send_pulse(1'b1, 16'd0);
    endtask

    // class edges at unit 300, exact boundaries abort, low pulse ignored mid-frame
    task automatic test_bit_boundaries();
        send_pulse(1'b0, 16'd6900);
        send_pulse(1'b0, 16'd9000);
        send_pulse(1'b1, bit_width(300, 1'b0, 0));
        send_pulse(1'b1, bit_width(300, 1'b0, 1));
        send_pulse(1'b1, bit_width(300, 1'b1, 0));
        send_pulse(1'b1, bit_width(300, 1'b1, 1));
        send_pulse(1'b1, 16'd450);
        send_pulse(1'b0, 16'd6900);
        send_pulse(1'b1, 16'd150);
        send_pulse(1'b0, 16'd6900);
        send_pulse(1'b1, 16'd750);
    endtask

    task automatic test_good_frame();
        send_frame(16'd6923, {15'h4B2D, 13'h0A65}, NO_ABORT, 50);
    endtask

    task automatic test_bad_end_code();
        send_frame(16'd7360, {15'h7FFF, 13'h1FFA}, NO_ABORT, 0);
    endtask

    // widest window, unit time clamps at its 9-bit ceiling
    task automatic test_large_pilot();
        set_bounds(16'd0, 16'hFFFF);
        send_frame(16'hFFFE, {15'h0000, 13'h0005}, NO_ABORT, 0);
    endtask

    // mostly well-formed frames with random content, plus noise and broken frames
    task automatic run_random(input int unsigned count);
        int unsigned start;
        logic [27:0] code;
        int          abort_at;
        start = pulses_sent;
        while (pulses_sent - start < count) begin
            no_stall = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) != 0) begin
                code = 28'($urandom);
                if ($urandom_range(0, 9) < 7)
                    code[3:0] = END_CODE;
                abort_at = ($urandom_range(0, 6) == 0) ? int'($urandom_range(0, 27)) : NO_ABORT;
                send_frame(pick_pilot(), code, abort_at, $urandom_range(0, 1) * 20);
            end else begin
                send_noise($urandom_range(1, 6));
            end
        end
        no_stall = 1'b0;
    endtask

    task automatic test_random_windows();
        run_random(400);
        set_bounds(16'd0, 16'hFFFF);
        run_random(450);
        set_bounds(16'd0, 16'd120);
        run_random(300);
        set_bounds(16'hFFFF, 16'd0);
        run_random(60);
        set_bounds(16'd3000, 16'd3100);
        run_random(350);
        set_bounds(PILOT_MIN_RESET, PILOT_MAX_RESET);
        run_random(300);
    endtask

    // result side: random stalls, compare each frame with the oldest prediction
    initial begin
        int unsigned stall;
        t_out_res    got;
        t_out_res    want;
        wait (rst_n);
        @(posedge clk);
        forever begin
            stall = no_stall ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got = out_res;
            frames_seen++;
            if (got.frame_ok)
                good_frames++;
            if (expected_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected frame: ok=%0b first=%h second=%h",
                             got.frame_ok, got.first_part, got.second_part);
            end else begin
                want = expected_frames.pop_front();
                if (got.frame_ok !== want.frame_ok || got.first_part !== want.first_part ||
                    got.second_part !== want.second_part) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"frame mismatch: expected ok=%0b first=%h second=%h, ",
                                  "got ok=%0b first=%h second=%h"},
                                 want.frame_ok, want.first_part, want.second_part,
                                 got.frame_ok, got.first_part, got.second_part);
                end
            end
        end
    end

    // test sequence
    initial begin
        reset_decoder_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_pilot_bounds();
        test_bit_boundaries();
        test_good_frame();
        test_bad_end_code();
        test_large_pilot();
        test_random_windows();
        wait_idle();
        $display("pulse requests sent: %0d across six pilot windows incl. widest and empty",
                 pulses_sent);
        $display("frames decoded: %0d, %0d with a valid end code", frames_seen, good_frames);
        if (mismatches == 0 && expected_frames.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
